>>> sv/vn3_pkg.sv
// ----------------------------------------------------------------------------
// vn3_pkg
// Widths and types shared by the 3D vector normaliser and its interfaces.
// ----------------------------------------------------------------------------
package vn3_pkg;

  localparam int IN_WIDTH      = 24;
  localparam int OUT_FRAC_BITS = 30;
  localparam int OUT_WIDTH     = 32;
  localparam int LANES         = 3;

  // sum of three squares stays below 2^(2*IN_WIDTH)
  localparam int SUM_W  = 2 * IN_WIDTH;
  localparam int ROOT_W = IN_WIDTH;
  localparam int REM_W  = ROOT_W + 2;
  // quotient never exceeds 2^OUT_FRAC_BITS
  localparam int QUO_W  = OUT_FRAC_BITS + 1;

  typedef logic signed [IN_WIDTH-1:0]  comp_t;
  typedef logic signed [OUT_WIDTH-1:0] unit_t;
  typedef logic [IN_WIDTH-1:0]         mag_t;
  typedef logic [SUM_W-1:0]            sum_t;
  typedef logic [ROOT_W-1:0]           root_t;
  typedef logic [REM_W-1:0]            srem_t;
  typedef logic [QUO_W-1:0]            quo_t;

endpackage

>>> sv/vn3_vec_if.sv
// ----------------------------------------------------------------------------
// vn3_vec_if
// Input channel: one signed 3-component vector per beat.
// ----------------------------------------------------------------------------
interface vn3_vec_if;
  logic          valid;
  logic          ready;
  vn3_pkg::comp_t vec_x;
  vn3_pkg::comp_t vec_y;
  vn3_pkg::comp_t vec_z;

  modport source (output valid, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

>>> sv/vn3_unit_if.sv
// ----------------------------------------------------------------------------
// vn3_unit_if
// Output channel: one normalised Q1.30 vector and a zero-length flag per beat.
// ----------------------------------------------------------------------------
interface vn3_unit_if;
  logic           valid;
  logic           ready;
  vn3_pkg::unit_t unit_x;
  vn3_pkg::unit_t unit_y;
  vn3_pkg::unit_t unit_z;
  logic           zero_length;

  modport source (output valid, unit_x, unit_y, unit_z, zero_length, input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, zero_length, output ready);
endinterface

>>> sv/vector_normalize_3d.sv
// ----------------------------------------------------------------------------
// vector_normalize_3d
// Normalises a signed 3-component vector to a Q1.30 unit vector.
// ----------------------------------------------------------------------------
// One vector is accepted per cycle and one result leaves per cycle, through
// the sign/magnitude, square and sum registers, the bit-per-stage square root
// (one root bit per stage), three bit-per-stage dividers (one quotient bit per
// stage) and the output register. The whole pipe holds while the output beat is
// not taken. The length is floor(sqrt(x^2+y^2+z^2));
// each component is divided by it with truncation toward zero. An all-zero
// vector gives zero components with zero_length set.
module vector_normalize_3d (
  input  logic       clk,
  input  logic       rst,
  vn3_vec_if.sink    vec_in,
  vn3_unit_if.source unit_out
);

  localparam int W  = vn3_pkg::IN_WIDTH;
  localparam int RW = vn3_pkg::ROOT_W;
  localparam int QW = vn3_pkg::QUO_W;
  localparam int NL = vn3_pkg::LANES;

  logic en;

  // ---------------- stage A: sign and magnitude
  logic                          a_vld;
  logic [NL-1:0][W-1:0]          a_mag;
  logic [NL-1:0]                 a_neg;
  logic [NL-1:0][W-1:0]          in_raw;

  assign in_raw = {vec_in.vec_z, vec_in.vec_y, vec_in.vec_x};

  // whole pipe advances when the output slot is free or being taken
  assign en           = !unit_out.valid || unit_out.ready;
  assign vec_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= vec_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NL; i++) begin
        a_neg[i] <= in_raw[i][W-1];
        a_mag[i] <= in_raw[i][W-1] ? W'(~in_raw[i] + W'(1)) : in_raw[i];
      end
    end
  end

  // ---------------- stage B: squares
  logic                              b_vld;
  logic [NL-1:0][vn3_pkg::SUM_W-1:0] b_sq;
  logic [NL-1:0][W-1:0]              b_mag;
  logic [NL-1:0]                     b_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NL; i++) begin
        b_sq[i] <= a_mag[i] * a_mag[i];
      end
      b_mag <= a_mag;
      b_neg <= a_neg;
    end
  end

  // ---------------- stage C: sum of squares
  logic                 c_vld;
  vn3_pkg::sum_t        c_sum;
  logic [NL-1:0][W-1:0] c_mag;
  logic [NL-1:0]        c_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sum <= vn3_pkg::SUM_W'(b_sq[0] + b_sq[1] + b_sq[2]);
      c_mag <= b_mag;
      c_neg <= b_neg;
    end
  end

  // ---------------- square root: one root bit per stage
  logic                 sr_vld  [0:RW];
  vn3_pkg::sum_t        sr_s    [0:RW];
  vn3_pkg::srem_t       sr_rem  [0:RW];
  vn3_pkg::root_t       sr_root [0:RW];
  logic [NL-1:0][W-1:0] sr_mag  [0:RW];
  logic [NL-1:0]        sr_neg  [0:RW];

  assign sr_vld[0]  = c_vld;
  assign sr_s[0]    = c_sum;
  assign sr_rem[0]  = '0;
  assign sr_root[0] = '0;
  assign sr_mag[0]  = c_mag;
  assign sr_neg[0]  = c_neg;

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    logic [vn3_pkg::REM_W+1:0] cat;
    logic [vn3_pkg::REM_W+1:0] sub;
    logic                      ge;

    // bring down two bits, try subtracting 4*root+1
    assign cat = {sr_rem[j], sr_s[j][vn3_pkg::SUM_W-1 -: 2]};
    assign sub = (vn3_pkg::REM_W+2)'({sr_root[j], 2'b01});
    assign ge  = cat >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        sr_vld[j+1] <= 1'b0;
      end else if (en) begin
        sr_vld[j+1] <= sr_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr_s[j+1]    <= {sr_s[j][vn3_pkg::SUM_W-3:0], 2'b00};
        sr_rem[j+1]  <= ge ? vn3_pkg::REM_W'(cat - sub) : vn3_pkg::REM_W'(cat);
        sr_root[j+1] <= {sr_root[j][RW-2:0], ge};
        sr_mag[j+1]  <= sr_mag[j];
        sr_neg[j+1]  <= sr_neg[j];
      end
    end
  end

  // ---------------- division: one quotient bit per stage, three lanes
  // dividend is mag << OUT_FRAC_BITS; starting remainder mag>>1 is below len,
  // the first step brings in the magnitude lsb and the rest bring in zeros
  logic                  dv_vld [0:QW];
  vn3_pkg::root_t        dv_len [0:QW];
  logic [NL-1:0][RW-1:0] dv_rem [0:QW];
  logic [NL-1:0][QW-1:0] dv_quo [0:QW];
  logic [NL-1:0]         dv_lsb;
  logic [NL-1:0]         dv_neg [0:QW];

  assign dv_vld[0] = sr_vld[RW];
  assign dv_len[0] = sr_root[RW];
  assign dv_neg[0] = sr_neg[RW];
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      dv_rem[0][i] = RW'(sr_mag[RW][i] >> 1);
      dv_quo[0][i] = '0;
      dv_lsb[i]    = sr_mag[RW][i][0];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [NL-1:0] bit_in;

    if (k == 0) begin : g_first
      assign bit_in = dv_lsb;
    end else begin : g_rest
      assign bit_in = '0;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k+1] <= 1'b0;
      end else if (en) begin
        dv_vld[k+1] <= dv_vld[k];
      end
    end

    for (genvar i = 0; i < NL; i++) begin : g_lane
      logic [RW:0] sh;
      logic        ge;

      assign sh = {dv_rem[k][i], bit_in[i]};
      assign ge = sh >= (RW+1)'(dv_len[k]);

      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem[k+1][i] <= ge ? RW'(sh - (RW+1)'(dv_len[k])) : RW'(sh);
          dv_quo[k+1][i] <= {dv_quo[k][i][QW-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_len[k+1] <= dv_len[k];
        dv_neg[k+1] <= dv_neg[k];
      end
    end
  end

  // ---------------- output register: sign, zero-length handling
  logic                                 zero_len;
  logic [NL-1:0][vn3_pkg::OUT_WIDTH-1:0] res;

  assign zero_len = dv_len[QW] == '0;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      res[i] = vn3_pkg::OUT_WIDTH'(dv_quo[QW][i]);
      if (dv_neg[QW][i]) begin
        res[i] = vn3_pkg::OUT_WIDTH'(~res[i] + vn3_pkg::OUT_WIDTH'(1));
      end
      if (zero_len) begin
        res[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_out.valid <= 1'b0;
    end else if (en) begin
      unit_out.valid <= dv_vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_out.unit_x      <= res[0];
      unit_out.unit_y      <= res[1];
      unit_out.unit_z      <= res[2];
      unit_out.zero_length <= zero_len;
    end
  end

`ifndef ASSERT_OFF
  localparam logic signed [vn3_pkg::OUT_WIDTH-1:0] ONE_Q =
    vn3_pkg::OUT_WIDTH'(1) << vn3_pkg::OUT_FRAC_BITS;

  // input side may only take a beat when the output slot can move
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    vec_in.ready == (!unit_out.valid || unit_out.ready))
    else $error("input ready does not follow output slot");

  // a zero-length result carries zero components
  a_zero_gives_zero: assert property (@(posedge clk) disable iff (rst)
    unit_out.valid && unit_out.zero_length |->
      unit_out.unit_x == '0 && unit_out.unit_y == '0 && unit_out.unit_z == '0)
    else $error("zero-length result with non-zero components");

  // every component of a unit vector lies within plus or minus one
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    unit_out.valid |->
      unit_out.unit_x <= ONE_Q && unit_out.unit_x >= -ONE_Q &&
      unit_out.unit_y <= ONE_Q && unit_out.unit_y >= -ONE_Q &&
      unit_out.unit_z <= ONE_Q && unit_out.unit_z >= -ONE_Q)
    else $error("unit component out of range");

  // a stalled output beat keeps its valid bit
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    unit_out.valid && !unit_out.ready |=> unit_out.valid)
    else $error("output beat dropped under stall");
`endif

endmodule

>>> test/tb_vn3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vn3_checker
// Watches both channels of the vector normaliser, works out the expected unit
// vector for every accepted input beat and compares each output beat with it.
// ----------------------------------------------------------------------------
module tb_vn3_checker (
  input  logic    clk,
  input  logic    rst,
  vn3_vec_if.sink vec_mon,
  vn3_unit_if.sink unit_mon,
  output int      fail_count,
  output int      pending,
  output int      seen_zero,
  output int      seen_full
);

  typedef struct packed {
    vn3_pkg::unit_t ux;
    vn3_pkg::unit_t uy;
    vn3_pkg::unit_t uz;
    logic           zl;
  } unit_res_t;

  unit_res_t unit_queue[$];

  // integer floor square root, one bit pair at a time
  function automatic longint unsigned isqrt(longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic unit_res_t normalise(vn3_pkg::comp_t x, vn3_pkg::comp_t y,
                                          vn3_pkg::comp_t z);
    longint signed c[3];
    longint unsigned m[3];
    longint unsigned s;
    longint unsigned len;
    longint unsigned q;
    vn3_pkg::unit_t u[3];
    unit_res_t r;
    c[0] = x;
    c[1] = y;
    c[2] = z;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (c[i] < 0) ? -c[i] : c[i];
      s += m[i] * m[i];
    end
    len = isqrt(s);
    if (len == 0) begin
      r = '{ux: '0, uy: '0, uz: '0, zl: 1'b1};
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      q = (m[i] << vn3_pkg::OUT_FRAC_BITS) / len;
      if (c[i] < 0) q = -q;
      u[i] = q[vn3_pkg::OUT_WIDTH-1:0];
    end
    r = '{ux: u[0], uy: u[1], uz: u[2], zl: 1'b0};
    return r;
  endfunction

  assign pending = unit_queue.size();

  always @(posedge clk) begin
    unit_res_t want;
    if (rst) begin
      fail_count = 0;
      seen_zero  = 0;
      seen_full  = 0;
    end else begin
      if (vec_mon.valid && vec_mon.ready) begin
        unit_queue.push_back(normalise(vec_mon.vec_x, vec_mon.vec_y, vec_mon.vec_z));
      end
      if (unit_mon.valid && unit_mon.ready) begin
        if (unit_queue.size() == 0) begin
          $display("%0t: unexpected output beat x=%0d y=%0d z=%0d zl=%0b", $time,
                   unit_mon.unit_x, unit_mon.unit_y, unit_mon.unit_z,
                   unit_mon.zero_length);
          fail_count++;
        end else begin
          want = unit_queue.pop_front();
          if (unit_mon.zero_length) seen_zero++;
          if (unit_mon.unit_x == (1 << 30) || unit_mon.unit_x == -(1 << 30)) seen_full++;
          if (unit_mon.unit_x !== want.ux || unit_mon.unit_y !== want.uy ||
              unit_mon.unit_z !== want.uz || unit_mon.zero_length !== want.zl) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d zl=%0b", $time,
                     want.ux, want.uy, want.uz, want.zl);
            $display("%0t:          actual   x=%0d y=%0d z=%0d zl=%0b", $time,
                     unit_mon.unit_x, unit_mon.unit_y, unit_mon.unit_z,
                     unit_mon.zero_length);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

>>> test/tb_vector_normalize_3d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_normalize_3d
// Drives directed and random vectors through the normaliser with random
// idling on both channels; the checker module does the comparing.
// ----------------------------------------------------------------------------
module tb_vector_normalize_3d;

  localparam int N_RANDOM  = 700;
  localparam int MAX_CYCLE = 200000;
  localparam int DRAIN     = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   seen_zero;
  int   seen_full;
  int   cycle = 0;
  int   beats = 0;
  bit   calm = 1'b0;
  int   ready_hold = 0;

  vn3_vec_if  vec_ch ();
  vn3_unit_if unit_ch ();

  vector_normalize_3d dut (
    .clk      (clk),
    .rst      (rst),
    .vec_in   (vec_ch.sink),
    .unit_out (unit_ch.source)
  );

  tb_vn3_checker chk (
    .clk        (clk),
    .rst        (rst),
    .vec_mon    (vec_ch.sink),
    .unit_mon   (unit_ch.sink),
    .fail_count (fail_count),
    .pending    (pending),
    .seen_zero  (seen_zero),
    .seen_full  (seen_full)
  );

  always #2 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("FAILURE");
      $finish;
    end
  end

  // output stall in random bursts, none near the end
  always @(posedge clk) begin
    if (rst) begin
      unit_ch.ready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      unit_ch.ready <= 1'b0;
      ready_hold    <= $urandom_range(1, 12) - 1;
    end else begin
      unit_ch.ready <= 1'b1;
    end
  end

  function automatic vn3_pkg::comp_t rand_comp(int kind);
    unique case (kind)
      0: return vn3_pkg::comp_t'($urandom);
      1: return vn3_pkg::comp_t'($signed($urandom_range(0, 15)) - 8);
      2: return $urandom_range(0, 1) ? vn3_pkg::comp_t'(24'h7fffff)
                                     : vn3_pkg::comp_t'(24'h800000);
      default: return vn3_pkg::comp_t'($signed($urandom_range(0, 4095)) - 2048);
    endcase
  endfunction

  // one beat: optional idle burst, then hold valid until taken
  task automatic send_vec(vn3_pkg::comp_t x, vn3_pkg::comp_t y, vn3_pkg::comp_t z);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      vec_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vec_ch.valid <= 1'b1;
    vec_ch.vec_x <= x;
    vec_ch.vec_y <= y;
    vec_ch.vec_z <= z;
    do @(posedge clk); while (!vec_ch.ready);
    beats++;
  endtask

  initial begin
    vn3_pkg::comp_t mx;
    vn3_pkg::comp_t mn;
    mx = vn3_pkg::comp_t'(24'h7fffff);
    mn = vn3_pkg::comp_t'(24'h800000);
    vec_ch.valid = 1'b0;
    vec_ch.vec_x = '0;
    vec_ch.vec_y = '0;
    vec_ch.vec_z = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero vector, axes, extremes, mixed signs
    send_vec(0, 0, 0);
    send_vec(1, 0, 0);
    send_vec(0, -1, 0);
    send_vec(0, 0, 1);
    send_vec(mx, 0, 0);
    send_vec(mn, 0, 0);
    send_vec(0, mn, 0);
    send_vec(0, 0, mx);
    send_vec(mx, mx, mx);
    send_vec(mn, mn, mn);
    send_vec(mx, mn, mx);
    send_vec(mn, mx, mn);
    send_vec(1, 1, 1);
    send_vec(-1, -1, -1);
    send_vec(3, 4, 0);
    send_vec(-3, 0, -4);
    send_vec(1, 2, 2);
    send_vec(mn, 1, -1);
    send_vec(-1, 0, 0);
    send_vec(0, 0, 0);

    // random part; the tail runs with no idling
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 100) calm = 1'b1;
      if ($urandom_range(0, 30) == 0)
        send_vec(0, 0, 0);
      else
        send_vec(rand_comp($urandom_range(0, 3)), rand_comp($urandom_range(0, 3)),
                 rand_comp($urandom_range(0, 3)));
    end
    vec_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d vectors with idling on both channels; %0d zero-length, %0d full-scale x",
             beats, seen_zero, seen_full);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
